### design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros, clocked on the rising edge and
// disabled while the synchronous active-low reset is asserted
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define SCA_ASSERT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// antecedent implies consequent in the next cycle
`define SCA_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/sca_pkg.sv
// ----------------------------------------------------------------------------
// sca_pkg
// types, scancode constants and keymap tables for the set-1 scancode
// to ascii translator
// ----------------------------------------------------------------------------
package sca_pkg;

  // special scancodes
  localparam logic [7:0] CODE_PREFIX    = 8'hE0;
  localparam logic [7:0] CODE_UP        = 8'h48;
  localparam logic [7:0] CODE_DOWN      = 8'h50;
  localparam logic [7:0] CODE_LEFT      = 8'h4B;
  localparam logic [7:0] CODE_RIGHT     = 8'h4D;
  localparam logic [7:0] CODE_LSHIFT_DN = 8'h2A;
  localparam logic [7:0] CODE_LSHIFT_UP = 8'hAA;
  localparam logic [7:0] CODE_RSHIFT_DN = 8'h36;
  localparam logic [7:0] CODE_RSHIFT_UP = 8'hB6;
  localparam logic [7:0] CODE_CAPS      = 8'h3A;

  // lower-case letter range and case offset
  localparam logic [6:0] ASCII_LOWER_A = 7'd97;
  localparam logic [6:0] ASCII_LOWER_Z = 7'd122;
  localparam logic [6:0] ASCII_CASE_OFS = 7'd32;

  // keymap covers codes 0..57, padded with zeros to 64 entries
  localparam int unsigned MAP_DEPTH = 64;

  typedef enum logic [2:0] {
    MOVE_NONE  = 3'd0,
    MOVE_UP    = 3'd1,
    MOVE_DOWN  = 3'd2,
    MOVE_LEFT  = 3'd3,
    MOVE_RIGHT = 3'd4
  } move_t;

  // keyboard mode flags kept between beats
  typedef struct packed {
    logic shift_held;
    logic caps_on;
    logic prefix_pending;
  } flags_t;

  // one translated result beat
  typedef struct packed {
    logic       char_valid;
    logic [6:0] char_code;
    move_t      cursor_move;
    logic       shift_now;
    logic       caps_now;
  } result_t;

  localparam logic [6:0] MAP_PLAIN [MAP_DEPTH] = '{
    7'h00, 7'h1B, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36,
    7'h37, 7'h38, 7'h39, 7'h30, 7'h2D, 7'h3D, 7'h08, 7'h09,
    7'h71, 7'h77, 7'h65, 7'h72, 7'h74, 7'h79, 7'h75, 7'h69,
    7'h6F, 7'h70, 7'h5B, 7'h5D, 7'h0A, 7'h00, 7'h61, 7'h73,
    7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B, 7'h6C, 7'h3B,
    7'h27, 7'h60, 7'h00, 7'h5C, 7'h7A, 7'h78, 7'h63, 7'h76,
    7'h62, 7'h6E, 7'h6D, 7'h2C, 7'h2E, 7'h2F, 7'h00, 7'h2A,
    7'h00, 7'h20, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00
  };

  localparam logic [6:0] MAP_SHIFTED [MAP_DEPTH] = '{
    7'h00, 7'h1B, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E,
    7'h26, 7'h2A, 7'h28, 7'h29, 7'h5F, 7'h2B, 7'h08, 7'h09,
    7'h51, 7'h57, 7'h45, 7'h52, 7'h54, 7'h59, 7'h55, 7'h49,
    7'h4F, 7'h50, 7'h7B, 7'h7D, 7'h0A, 7'h00, 7'h41, 7'h53,
    7'h44, 7'h46, 7'h47, 7'h48, 7'h4A, 7'h4B, 7'h4C, 7'h3A,
    7'h22, 7'h7E, 7'h00, 7'h7C, 7'h5A, 7'h58, 7'h43, 7'h56,
    7'h42, 7'h4E, 7'h4D, 7'h3C, 7'h3E, 7'h3F, 7'h00, 7'h2A,
    7'h00, 7'h20, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00
  };

endpackage

### design/sca_xlate.sv
// ----------------------------------------------------------------------------
// sca_xlate
// combinational translation of one scancode: flag update, keymap lookup,
// caps handling and extended cursor decode
// ----------------------------------------------------------------------------
module sca_xlate (
  input  logic [7:0]       scancode,
  input  sca_pkg::flags_t  flags,
  output sca_pkg::flags_t  flags_nxt,
  output sca_pkg::result_t result
);

  logic       in_map;
  logic [6:0] plain_char;
  logic [6:0] map_char;
  logic [6:0] ch;
  sca_pkg::move_t move;

  // keymap lookup, codes 58 and above give nothing
  always_comb begin
    in_map     = (scancode[7:6] == 2'b00) &&
                 (scancode[5:0] < 6'(58));
    plain_char = sca_pkg::MAP_PLAIN[scancode[5:0]];
    if (!in_map) begin
      map_char = '0;
    end else if (flags.shift_held) begin
      map_char = sca_pkg::MAP_SHIFTED[scancode[5:0]];
    end else if (flags.caps_on && (plain_char inside
                 {[sca_pkg::ASCII_LOWER_A:sca_pkg::ASCII_LOWER_Z]})) begin
      map_char = plain_char - sca_pkg::ASCII_CASE_OFS;
    end else begin
      map_char = plain_char;
    end
  end

  // flag update and result selection
  always_comb begin
    flags_nxt = flags;
    ch        = '0;
    move      = sca_pkg::MOVE_NONE;
    if (flags.prefix_pending) begin
      case (scancode)
        sca_pkg::CODE_UP:    move = sca_pkg::MOVE_UP;
        sca_pkg::CODE_DOWN:  move = sca_pkg::MOVE_DOWN;
        sca_pkg::CODE_LEFT:  move = sca_pkg::MOVE_LEFT;
        sca_pkg::CODE_RIGHT: move = sca_pkg::MOVE_RIGHT;
        default:             move = sca_pkg::MOVE_NONE;
      endcase
      flags_nxt.prefix_pending = (scancode == sca_pkg::CODE_PREFIX);
    end else begin
      case (scancode)
        sca_pkg::CODE_LSHIFT_DN, sca_pkg::CODE_RSHIFT_DN: begin
          flags_nxt.shift_held = 1'b1;
        end
        sca_pkg::CODE_LSHIFT_UP, sca_pkg::CODE_RSHIFT_UP: begin
          flags_nxt.shift_held = 1'b0;
        end
        sca_pkg::CODE_CAPS: begin
          flags_nxt.caps_on = ~flags.caps_on;
        end
        default: begin
          ch = map_char;
          flags_nxt.prefix_pending = (scancode == sca_pkg::CODE_PREFIX);
        end
      endcase
    end
  end

  // pack result beat
  always_comb begin
    result.char_valid  = (ch != '0);
    result.char_code   = ch;
    result.cursor_move = move;
    result.shift_now   = flags_nxt.shift_held;
    result.caps_now    = flags_nxt.caps_on;
  end

endmodule

### design/scancode_to_ascii_translator.sv
// ----------------------------------------------------------------------------
// scancode_to_ascii_translator
// set-1 keyboard scancode to ascii translator with shift, caps lock and
// extended-prefix cursor keys, one result beat per scancode beat
// ----------------------------------------------------------------------------
//
//  channel | dir | payload                                   | handshake
//  --------+-----+-------------------------------------------+-----------------
//  in_     | in  | tdata[7:0] scancode                       | tvalid / tready
//  out_    | out | tuser char_valid, tdata[11:0] code/move/  | tvalid / tready
//          |     | shift/caps                                |
//
//  an input beat passes an input register, then one pass of table lookup
//  and flag update into the result register. one beat per cycle is
//  sustained while out_tready is high; the mode flags loop through flags_r.
//  a stalled result holds in the result register while the input register
//  keeps its beat; in_tready follows out_tready through both stages.
//  reset clears the valid bits and the shift, caps and prefix flags.
//
`include "assert_macros.svh"

module scancode_to_ascii_translator (
  input  logic        clk,
  input  logic        rst_n,
  // input beat
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] scancode
  // result beat
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic        out_tuser,  // [0] char_valid
  output logic [15:0] out_tdata   // [6:0] char_code, [9:7] cursor_move,
                                  // [10] shift_now, [11] caps_now, [15:12] zero
);

  logic              in_v_r;
  logic [7:0]        in_code_r;
  logic              out_v_r;
  sca_pkg::result_t  out_res_r;
  sca_pkg::flags_t   flags_r;
  sca_pkg::flags_t   flags_nxt;
  sca_pkg::result_t  res_nxt;
  logic              adv;
  logic              in_acc;

  // stage handshake
  assign adv       = in_v_r && (!out_v_r || out_tready);
  assign in_tready = !in_v_r || adv;
  assign in_acc    = in_tvalid && in_tready;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_tready) begin
      in_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      in_code_r <= in_tdata;
    end
  end

  // translation logic
  sca_xlate u_xlate (
    .scancode  (in_code_r),
    .flags     (flags_r),
    .flags_nxt (flags_nxt),
    .result    (res_nxt)
  );

  // mode flags advance with each translated beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flags_r <= '0;
    end else if (adv) begin
      flags_r <= flags_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (adv) begin
      out_v_r <= 1'b1;
    end else if (out_tready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_res_r <= res_nxt;
    end
  end

  // output packing
  assign out_tvalid = out_v_r;
  assign out_tuser  = out_res_r.char_valid;
  assign out_tdata  = {4'b0000, out_res_r.caps_now, out_res_r.shift_now,
                       out_res_r.cursor_move, out_res_r.char_code};

  // a cursor move never comes with a character
  `SCA_ASSERT(a_move_no_char, clk, rst_n,
              out_v_r && (out_res_r.cursor_move != sca_pkg::MOVE_NONE),
              !out_res_r.char_valid, "cursor move with character")
  // char_valid matches a nonzero code
  `SCA_ASSERT(a_valid_code, clk, rst_n, out_v_r,
              out_res_r.char_valid == (out_res_r.char_code != 7'd0),
              "char_valid disagrees with char_code")
  // flags move only when a beat is translated
  `SCA_ASSERT_NXT(a_flags_hold, clk, rst_n, !adv, $stable(flags_r),
                  "flags changed without a beat")
  // a prefixed byte other than the prefix clears the pending prefix
  `SCA_ASSERT_NXT(a_prefix_clear, clk, rst_n,
                  adv && flags_r.prefix_pending && (in_code_r != sca_pkg::CODE_PREFIX),
                  !flags_r.prefix_pending, "prefix not cleared")
  // reported flags match the held flags after the beat
  `SCA_ASSERT_NXT(a_flags_report, clk, rst_n, adv,
                  (out_res_r.shift_now == flags_r.shift_held) &&
                  (out_res_r.caps_now == flags_r.caps_on),
                  "reported flags differ from state")

endmodule
